FILE: hw/rtl/cegu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cegu_pkg
// Shared types, constants and the quarter-wave sine table of the cone
// evidence grid.
// ----------------------------------------------------------------------------
package cegu_pkg;

  // Default map size
  localparam int MAP_ROWS_DEF = 512;
  localparam int MAP_COLS_DEF = 512;

  // Evidence update: v = min(v + step, cap)
  localparam logic [7:0] EVID_STEP = 8'd50;
  localparam logic [7:0] EVID_CAP  = 8'd250;
  localparam int         LANE_W    = 8;
  localparam int         CELL_W    = 3 * LANE_W;

  // Configuration port
  localparam int         CFG_ADDR_W   = 3;
  localparam logic       REG_PPM      = 1'b0;
  localparam logic [15:0] PPM_RESET   = 16'd25600;

  // Datapath widths
  localparam int MAC_A_W = 32;
  localparam int MAC_B_W = 18;
  localparam int ACC_W   = 50;
  localparam int POS_W   = 20;

  // Cone classes
  localparam logic [7:0] CLASS_ZERO = 8'd0;
  localparam logic [7:0] CLASS_ONE  = 8'd1;
  localparam logic [7:0] CLASS_TWO  = 8'd2;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    LANE_0 = 2'd0,
    LANE_1 = 2'd1,
    LANE_2 = 2'd2
  } lane_t;

  typedef struct packed {
    op_t                operation;
    logic signed [15:0] cone_x;
    logic signed [15:0] cone_y;
    logic [7:0]         cone_class;
    logic signed [15:0] vehicle_col;
    logic signed [15:0] vehicle_row;
    logic [11:0]        vehicle_heading;
    logic [8:0]         query_row;
    logic [8:0]         query_col;
  } cone_word_t;

  typedef struct packed {
    logic               placed;
    logic signed [15:0] pixel_col;
    logic signed [15:0] pixel_row;
    logic [7:0]         channel_zero;
    logic [7:0]         channel_one;
    logic [7:0]         channel_two;
  } result_word_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROM_S,
    ST_ROM_C,
    ST_MUL,
    ST_PLACE,
    ST_CHECK,
    ST_RD,
    ST_WR,
    ST_QUERY,
    ST_DONE
  } state_t;

  // Steps of the shared multiply-accumulate unit
  typedef enum logic [2:0] {
    MS_CX_C  = 3'd0,
    MS_CY_S  = 3'd1,
    MS_CY_C  = 3'd2,
    MS_CX_S  = 3'd3,
    MS_A_PPM = 3'd4,
    MS_B_PPM = 3'd5
  } mac_step_t;

  // Command to the multiply-accumulate unit
  typedef struct packed {
    logic                     en;
    logic                     sub;
    logic signed [MAC_A_W-1:0] a;
    logic signed [MAC_B_W-1:0] b;
    logic signed [ACC_W-1:0]   addend;
  } mac_op_t;

  // Quarter-wave sine, round(16384 * sin(r * pi / 2048)), r = 0..1024
  localparam int          QUARTER = 1024;
  localparam int          SINE_W  = 15;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;

  typedef logic [QUARTER:0][SINE_W-1:0] sine_rom_t;

  // Unsigned 64-bit quotient by shift and subtract (table build only)
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] part;
    quo  = '0;
    part = '0;
    for (int i = 63; i >= 0; i--) begin
      part = {part[63:0], num[i]};
      if (part >= {1'b0, den}) begin
        part   = part - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] den;
    logic [63:0] rnd;
    rom = '0;
    for (int r = 0; r <= QUARTER; r++) begin
      x    = (64'(r) * PI_Q30) >> 11;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      // Taylor series, alternating signs
      for (int n = 1; n <= 8; n++) begin
        den  = 64'((2 * n) * (2 * n + 1));
        term = udiv64((term * x2) >> 30, den);
        if (n[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      rnd    = (sum * 64'd16384 + (64'd1 << 29)) >> 30;
      rom[r] = rnd[SINE_W-1:0];
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Table index for a 12-bit binary angle (mirrored in odd quadrants)
  function automatic logic [10:0] sine_index(logic [11:0] h);
    logic [10:0] r;
    r = {1'b0, h[9:0]};
    return h[10] ? (11'd1024 - r) : r;
  endfunction

  // Truncate a Q.30 value toward zero
  function automatic logic signed [POS_W-1:0] trunc_q30(logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] biased;
    biased = v + {{(ACC_W-30){1'b0}}, {30{v[ACC_W-1]}}};
    return biased[ACC_W-1:30];
  endfunction

  // Saturate to 16-bit signed
  function automatic logic signed [15:0] sat16(logic signed [POS_W-1:0] v);
    logic signed [15:0] r;
    if (v > 20'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // One evidence step with saturation
  function automatic logic [7:0] bump(logic [7:0] v);
    logic [8:0] s;
    s = {1'b0, v} + {1'b0, EVID_STEP};
    return (s > {1'b0, EVID_CAP}) ? EVID_CAP : s[7:0];
  endfunction

endpackage

FILE: hw/rtl/cegu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cegu_if
// Valid/ready channels of the cone evidence grid: cone words in, result
// words out.
// ----------------------------------------------------------------------------
interface cegu_cone_if;
  logic                 valid;
  logic                 ready;
  cegu_pkg::cone_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cegu_result_if;
  logic                   valid;
  logic                   ready;
  cegu_pkg::result_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/cegu_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cegu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cegu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/cegu_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cegu_sine_rom
// Quarter-wave Q1.14 sine magnitude table with registered output.
// ----------------------------------------------------------------------------
module cegu_sine_rom (
  input  logic                        clk,
  input  logic [10:0]                 idx,
  output logic [cegu_pkg::SINE_W-1:0] q
);
  // idx never exceeds a quarter turn
  always_ff @(posedge clk) begin
    q <= cegu_pkg::SINE_ROM[idx];
  end
endmodule

FILE: hw/rtl/cegu_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cegu_mac
// Shared signed multiply-accumulate unit: acc <= addend +/- a * b.
// ----------------------------------------------------------------------------
module cegu_mac (
  input  logic                                clk,
  input  cegu_pkg::mac_op_t                   op,
  output logic signed [cegu_pkg::ACC_W-1:0]   acc
);
  logic signed [cegu_pkg::MAC_A_W-1:0] ma;
  logic signed [cegu_pkg::MAC_B_W-1:0] mb;
  logic signed [cegu_pkg::ACC_W-1:0]   prod;
  logic signed [cegu_pkg::ACC_W-1:0]   sum;

  assign ma   = op.a;
  assign mb   = op.b;
  assign prod = ma * mb;
  assign sum  = op.sub ? (op.addend - prod) : (op.addend + prod);

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= sum;
    end
  end
endmodule

FILE: hw/rtl/cegu_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cegu_cfg
// APB register file: holds the map scale register.
// ----------------------------------------------------------------------------
module cegu_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cegu_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output logic [15:0]                     ppm
);
  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[cegu_pkg::CFG_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register write
  always_ff @(posedge clk) begin
    if (rst) begin
      ppm <= cegu_pkg::PPM_RESET;
    end else if (wr_en && (reg_idx == cegu_pkg::REG_PPM)) begin
      ppm <= pwdata[15:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (psel && (reg_idx == cegu_pkg::REG_PPM)) begin
      prdata = {16'd0, ppm};
    end
  end
endmodule

FILE: hw/rtl/cone_evidence_grid_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cone_evidence_grid_update
// Cone evidence occupancy grid: places detected cones into a three-channel
// evidence map and reads back single cells.
// ----------------------------------------------------------------------------
// Usage:
//   cone   : valid/ready input. operation ADD rotates the cone by the vehicle
//            heading, scales it by the pixels-per-metre register, flips the
//            row and raises the 3x3 neighbourhood of one channel by 50 (cap
//            250). operation READ fetches the three channels of one cell.
//   result : valid/ready output, exactly one word per cone word.
//   APB    : register 0 (byte address 0) is pixels_per_metre, Q8.8.
// Timing: one item at a time. A read inside the map fetches the cell from
//   the map memory and then loads the result. An add that places a cone makes
//   2 sine table reads, 6 passes through the single shared multiply-accumulate
//   unit, coordinate handling in the PLACE and CHECK states, 9
//   read-modify-writes on the map memory and then loads the result; a
//   skipped add goes straight to the result (zero coordinate) or ends
//   after the CHECK state (outside the border or unknown class). The next
//   word is taken in the cycle after the result is loaded.
// Reset: a clearing pass writes every one of the MAP_ROWS * MAP_COLS map
//   cells to zero; cone.ready stays low meanwhile.
// Stall: the result sits in an output register; the next cone word is taken
//   while it waits, and its result is held back until the register drains.
// ----------------------------------------------------------------------------
module cone_evidence_grid_update #(
  parameter int MAP_ROWS = cegu_pkg::MAP_ROWS_DEF,
  parameter int MAP_COLS = cegu_pkg::MAP_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  cegu_cone_if.sink                       cone,
  cegu_result_if.source                   result,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [cegu_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  localparam int DEPTH  = MAP_ROWS * MAP_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = cegu_pkg::POS_W;
  localparam int ACC_W  = cegu_pkg::ACC_W;
  localparam int LW     = cegu_pkg::LANE_W;

  localparam logic signed [POS_W-1:0] ONE     = POS_W'(1);
  localparam logic signed [POS_W-1:0] COL_HI  = POS_W'(MAP_COLS - 2);
  localparam logic signed [POS_W-1:0] ROW_HI  = POS_W'(MAP_ROWS - 2);
  localparam logic signed [POS_W-1:0] ROWS_P  = POS_W'(MAP_ROWS);
  localparam logic [ADDR_W-1:0]       LAST_A  = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0]       COLS_A  = ADDR_W'(MAP_COLS);
  localparam logic [ADDR_W-1:0]       SKIP_A  = ADDR_W'(MAP_COLS - 2);
  localparam logic [12:0]             QROW_LM = 13'(MAP_ROWS);
  localparam logic [12:0]             QCOL_LM = 13'(MAP_COLS);

  cegu_pkg::state_t     state, state_next;
  cegu_pkg::mac_step_t  step;
  cegu_pkg::cone_word_t in_reg;
  cegu_pkg::result_word_t pend, out_reg;
  cegu_pkg::lane_t      lane;
  cegu_pkg::mac_op_t    mac_op;

  logic                       out_valid;
  logic                       accept;
  logic                       load_out;
  logic [ADDR_W-1:0]          clr_addr;
  logic [ADDR_W-1:0]          cell_addr;
  logic [ADDR_W-1:0]          query_addr;
  logic [3:0]                 cell_cnt;
  logic [1:0]                 dc_cnt;
  logic signed [15:0]         s_reg, c_reg;
  logic signed [31:0]         a_reg, b_reg;
  logic signed [ACC_W-1:0]    p_reg;
  logic signed [ACC_W-1:0]    acc;
  logic signed [POS_W-1:0]    col_reg, row_reg;
  logic [15:0]                ppm;
  logic [10:0]                rom_idx;
  logic [cegu_pkg::SINE_W-1:0] rom_q;
  logic [11:0]                head_c;
  logic                       query_in;
  logic                       in_bounds;
  logic                       class_ok;
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [cegu_pkg::CELL_W-1:0] ram_wdata;
  logic [cegu_pkg::CELL_W-1:0] ram_rdata;

  // --------------------------------------------------------------------------
  // Submodules
  // --------------------------------------------------------------------------
  cegu_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ppm     (ppm)
  );

  cegu_sine_rom u_rom (
    .clk (clk),
    .idx (rom_idx),
    .q   (rom_q)
  );

  cegu_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .acc (acc)
  );

  cegu_ram #(
    .WIDTH (cegu_pkg::CELL_W),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Decode helpers
  // --------------------------------------------------------------------------
  assign accept   = cone.valid && cone.ready;
  assign load_out = (state == cegu_pkg::ST_DONE) && (!out_valid || result.ready);
  assign head_c   = in_reg.vehicle_heading + 12'd1024;

  assign query_in = ({4'd0, cone.data.query_row} < QROW_LM) &&
                    ({4'd0, cone.data.query_col} < QCOL_LM);
  assign query_addr = ADDR_W'(cone.data.query_row) * COLS_A +
                      ADDR_W'(cone.data.query_col);

  assign in_bounds = (col_reg >= ONE) && (col_reg <= COL_HI) &&
                     (row_reg >= ONE) && (row_reg <= ROW_HI);
  assign class_ok = (in_reg.cone_class == cegu_pkg::CLASS_ZERO) ||
                    (in_reg.cone_class == cegu_pkg::CLASS_ONE) ||
                    (in_reg.cone_class == cegu_pkg::CLASS_TWO);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      cegu_pkg::ST_CLEAR: begin
        if (clr_addr == LAST_A) state_next = cegu_pkg::ST_IDLE;
      end
      cegu_pkg::ST_IDLE: begin
        if (accept) begin
          if (cone.data.operation == cegu_pkg::OP_READ) begin
            state_next = query_in ? cegu_pkg::ST_QUERY : cegu_pkg::ST_DONE;
          end else if ((cone.data.cone_x == '0) || (cone.data.cone_y == '0)) begin
            state_next = cegu_pkg::ST_DONE;
          end else begin
            state_next = cegu_pkg::ST_ROM_S;
          end
        end
      end
      cegu_pkg::ST_ROM_S: state_next = cegu_pkg::ST_ROM_C;
      cegu_pkg::ST_ROM_C: state_next = cegu_pkg::ST_MUL;
      cegu_pkg::ST_MUL: begin
        if (step == cegu_pkg::MS_B_PPM) state_next = cegu_pkg::ST_PLACE;
      end
      cegu_pkg::ST_PLACE: state_next = cegu_pkg::ST_CHECK;
      cegu_pkg::ST_CHECK: begin
        state_next = (in_bounds && class_ok) ? cegu_pkg::ST_RD : cegu_pkg::ST_DONE;
      end
      cegu_pkg::ST_RD: state_next = cegu_pkg::ST_WR;
      cegu_pkg::ST_WR: begin
        state_next = (cell_cnt == 4'd8) ? cegu_pkg::ST_DONE : cegu_pkg::ST_RD;
      end
      cegu_pkg::ST_QUERY: state_next = cegu_pkg::ST_DONE;
      cegu_pkg::ST_DONE: begin
        if (load_out) state_next = cegu_pkg::ST_IDLE;
      end
      default: state_next = cegu_pkg::ST_CLEAR;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the sequencer: handshake, table, MAC and memory controls
  // --------------------------------------------------------------------------
  always_comb begin
    cone.ready    = 1'b0;
    rom_idx       = cegu_pkg::sine_index(cone.data.vehicle_heading);
    mac_op        = '0;
    ram_we        = 1'b0;
    ram_waddr     = cell_addr;
    ram_wdata     = ram_rdata;
    ram_raddr     = cell_addr;
    unique case (state)
      cegu_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      cegu_pkg::ST_IDLE: begin
        cone.ready = 1'b1;
        ram_raddr  = query_addr;
      end
      cegu_pkg::ST_ROM_S: begin
        rom_idx = cegu_pkg::sine_index(head_c);
      end
      cegu_pkg::ST_MUL: begin
        mac_op.en = 1'b1;
        case (step)
          cegu_pkg::MS_CX_C: begin
            mac_op.a = 32'(in_reg.cone_x);
            mac_op.b = 18'(c_reg);
          end
          cegu_pkg::MS_CY_S: begin
            mac_op.a      = 32'(in_reg.cone_y);
            mac_op.b      = 18'(s_reg);
            mac_op.addend = acc;
          end
          cegu_pkg::MS_CY_C: begin
            mac_op.a = 32'(in_reg.cone_y);
            mac_op.b = 18'(c_reg);
          end
          cegu_pkg::MS_CX_S: begin
            mac_op.a      = 32'(in_reg.cone_x);
            mac_op.b      = 18'(s_reg);
            mac_op.addend = acc;
            mac_op.sub    = 1'b1;
          end
          cegu_pkg::MS_A_PPM: begin
            mac_op.a      = a_reg;
            mac_op.b      = {2'b00, ppm};
            mac_op.addend = {{8{in_reg.vehicle_col[15]}}, in_reg.vehicle_col, 26'd0};
          end
          cegu_pkg::MS_B_PPM: begin
            mac_op.a      = b_reg;
            mac_op.b      = {2'b00, ppm};
            mac_op.addend = {{8{in_reg.vehicle_row[15]}}, in_reg.vehicle_row, 26'd0};
          end
          default: mac_op.en = 1'b0;
        endcase
      end
      cegu_pkg::ST_WR: begin
        ram_we = 1'b1;
        unique case (lane)
          cegu_pkg::LANE_0: ram_wdata[0 +: LW]      = cegu_pkg::bump(ram_rdata[0 +: LW]);
          cegu_pkg::LANE_1: ram_wdata[LW +: LW]     = cegu_pkg::bump(ram_rdata[LW +: LW]);
          cegu_pkg::LANE_2: ram_wdata[2*LW +: LW]   = cegu_pkg::bump(ram_rdata[2*LW +: LW]);
          default:          ram_we                  = 1'b0;
        endcase
      end
      cegu_pkg::ST_ROM_C, cegu_pkg::ST_PLACE, cegu_pkg::ST_CHECK, cegu_pkg::ST_RD,
      cegu_pkg::ST_QUERY, cegu_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cegu_pkg::ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      step      <= cegu_pkg::MS_CX_C;
      cell_cnt  <= '0;
      dc_cnt    <= '0;
    end else begin
      state <= state_next;
      if (state == cegu_pkg::ST_CLEAR) clr_addr <= clr_addr + 1'b1;

      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      // MAC step counter
      if (state == cegu_pkg::ST_MUL) begin
        step <= cegu_pkg::mac_step_t'(3'(step) + 3'd1);
      end else begin
        step <= cegu_pkg::MS_CX_C;
      end

      // Neighbourhood counters
      if (state == cegu_pkg::ST_CHECK) begin
        cell_cnt <= '0;
        dc_cnt   <= '0;
      end else if (state == cegu_pkg::ST_WR) begin
        cell_cnt <= cell_cnt + 4'd1;
        dc_cnt   <= (dc_cnt == 2'd2) ? 2'd0 : (dc_cnt + 2'd1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg <= cone.data;
      pend   <= '0;
    end

    // Sine and cosine from the quarter table
    if (state == cegu_pkg::ST_ROM_S) begin
      s_reg <= in_reg.vehicle_heading[11] ? -16'(rom_q) : 16'(rom_q);
    end
    if (state == cegu_pkg::ST_ROM_C) begin
      c_reg <= head_c[11] ? -16'(rom_q) : 16'(rom_q);
    end

    // Capture rotated offsets and scaled column
    if (state == cegu_pkg::ST_MUL) begin
      if (step == cegu_pkg::MS_CY_C)  a_reg <= acc[31:0];
      if (step == cegu_pkg::MS_A_PPM) b_reg <= acc[31:0];
      if (step == cegu_pkg::MS_B_PPM) p_reg <= acc;
    end

    // Pixel coordinates, row flipped
    if (state == cegu_pkg::ST_PLACE) begin
      col_reg <= cegu_pkg::trunc_q30(p_reg);
      row_reg <= ROWS_P - cegu_pkg::trunc_q30(acc);
    end

    // Report coordinates, pick channel, top-left cell address
    if (state == cegu_pkg::ST_CHECK) begin
      pend.pixel_col <= cegu_pkg::sat16(col_reg);
      pend.pixel_row <= cegu_pkg::sat16(row_reg);
      pend.placed    <= in_bounds && class_ok;
      cell_addr      <= ADDR_W'($unsigned(row_reg - ONE)) * COLS_A +
                        ADDR_W'($unsigned(col_reg - ONE));
      unique case (in_reg.cone_class)
        cegu_pkg::CLASS_ONE: lane <= cegu_pkg::LANE_2;
        cegu_pkg::CLASS_TWO: lane <= cegu_pkg::LANE_1;
        default:             lane <= cegu_pkg::LANE_0;
      endcase
    end

    // Walk the 3x3 neighbourhood row by row
    if (state == cegu_pkg::ST_WR) begin
      cell_addr <= cell_addr + ((dc_cnt == 2'd2) ? SKIP_A : ADDR_W'(1));
    end

    // Cell read result
    if (state == cegu_pkg::ST_QUERY) begin
      pend.channel_zero <= ram_rdata[0 +: LW];
      pend.channel_one  <= ram_rdata[LW +: LW];
      pend.channel_two  <= ram_rdata[2*LW +: LW];
    end

    if (load_out) out_reg <= pend;
  end

  assign result.valid = out_valid;
  assign result.data  = out_reg;

endmodule

FILE: bench/tb_cone_evidence_grid_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cone_evidence_grid_update
// Self-checking bench for the cone evidence grid. It keeps its own copy of the
// evidence map and the scale register, and predicts each result word when the
// cone word is accepted. It runs directed border, class and extreme cases,
// then random phases of placements around busy spots, read-backs and noise
// under several scale settings. Both channel sides stall at random.
// ----------------------------------------------------------------------------
module tb_cone_evidence_grid_update;
  import cegu_pkg::*;

  localparam int MAP_ROWS       = MAP_ROWS_DEF;
  localparam int MAP_COLS       = MAP_COLS_DEF;
  localparam int WATCHDOG_LIMIT = 3 * MAP_ROWS * MAP_COLS;
  localparam int TAIL_CYCLES    = 40;
  localparam int SPOT_DEPTH     = 32;

  localparam logic [CFG_ADDR_W-1:0] PPM_ADDR      = CFG_ADDR_W'(4 * int'(REG_PPM));
  localparam logic [7:0]            CLASS_UNKNOWN = 8'd3;
  localparam logic [7:0]            CLASS_TOP     = 8'hFF;
  localparam logic [7:0]            MAPPED_CLASSES [3] = '{CLASS_ZERO, CLASS_ONE, CLASS_TWO};

  typedef struct packed {
    logic [8:0] row;
    logic [8:0] col;
  } spot_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cegu_cone_if   cone_ch ();
  cegu_result_if res_ch ();

  cone_evidence_grid_update #(
    .MAP_ROWS(MAP_ROWS),
    .MAP_COLS(MAP_COLS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .cone   (cone_ch),
    .result (res_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Predictor state: map lanes packed per cell, scale register, sine lookup
  bit [CELL_W-1:0] evid_cells [0:MAP_ROWS*MAP_COLS-1];
  logic [15:0]     scale_ppm = PPM_RESET;
  int              sin_lut [0:4095];

  result_word_t evidence_due [$];
  spot_t        spots [$];

  bit steady_flow = 1'b0;
  int sink_hold   = 0;
  int fault_count = 0;
  int n_adds      = 0;
  int n_placed    = 0;
  int n_reads     = 0;
  int n_lit_reads = 0;
  int n_capped    = 0;
  int n_scales    = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // round(16384 * sin(r * pi / 2048)) by fixed-point Taylor series, r = 0..1024
  function automatic int taylor_sin_q14(int r);
    bit [63:0] ang;
    bit [63:0] ang_sq;
    bit [63:0] term;
    bit [63:0] acc;
    ang    = (64'(r) * PI_Q30) >> 11;
    ang_sq = (ang * ang) >> 30;
    term   = ang;
    acc    = ang;
    for (int n = 1; n <= 8; n++) begin
      term = ((term * ang_sq) >> 30) / 64'((2 * n) * (2 * n + 1));
      acc  = ((n % 2) == 1) ? acc - term : acc + term;
    end
    return int'((acc * 64'd16384 + (64'd1 << 29)) >> 30);
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Expected result of one cone word; applies its map update
  function automatic result_word_t predict_evidence(cone_word_t w);
    result_word_t r;
    longint cx, cy, vc, vr, sn, cs, a, b, p, q, col, row;
    int     idx;
    lane_t  lane;
    logic [7:0] v;
    r = '0;
    if (w.operation == OP_READ) begin
      if (w.query_row < MAP_ROWS && w.query_col < MAP_COLS) begin
        idx = int'(w.query_row) * MAP_COLS + int'(w.query_col);
        r.channel_zero = evid_cells[idx][0 +: LANE_W];
        r.channel_one  = evid_cells[idx][LANE_W +: LANE_W];
        r.channel_two  = evid_cells[idx][2*LANE_W +: LANE_W];
      end
      return r;
    end
    cx = longint'($signed(w.cone_x));
    cy = longint'($signed(w.cone_y));
    vc = longint'($signed(w.vehicle_col));
    vr = longint'($signed(w.vehicle_row));
    // zero coordinate: nothing reported, nothing written
    if (cx == 0 || cy == 0) return r;
    sn  = sin_lut[int'(w.vehicle_heading)];
    cs  = sin_lut[(int'(w.vehicle_heading) + 1024) % 4096];
    a   = cx * cs + cy * sn;
    b   = cy * cs - cx * sn;
    p   = vc * (longint'(1) << 26) + a * longint'(scale_ppm);
    q   = vr * (longint'(1) << 26) + b * longint'(scale_ppm);
    col = p / (longint'(1) << 30);
    row = MAP_ROWS - q / (longint'(1) << 30);
    r.pixel_col = clip16(col);
    r.pixel_row = clip16(row);
    // border test on the unsaturated position
    if (col < 1 || col > MAP_COLS - 2 || row < 1 || row > MAP_ROWS - 2) return r;
    case (w.cone_class)
      CLASS_ZERO: lane = LANE_0;
      CLASS_ONE:  lane = LANE_2;
      CLASS_TWO:  lane = LANE_1;
      default:    return r;
    endcase
    for (longint dr = -1; dr <= 1; dr++) begin
      for (longint dc = -1; dc <= 1; dc++) begin
        idx = int'((row + dr) * MAP_COLS + (col + dc));
        v   = evid_cells[idx][int'(lane)*LANE_W +: LANE_W];
        v   = (int'(v) + int'(EVID_STEP) > int'(EVID_CAP)) ? EVID_CAP : v + EVID_STEP;
        evid_cells[idx][int'(lane)*LANE_W +: LANE_W] = v;
      end
    end
    r.placed = 1'b1;
    return r;
  endfunction

  function automatic cone_word_t add_word(int cx, int cy, logic [7:0] cls, int vc, int vr,
                                         int hdg);
    cone_word_t w;
    w                 = '0;
    w.operation       = OP_ADD;
    w.cone_x          = 16'(cx);
    w.cone_y          = 16'(cy);
    w.cone_class      = cls;
    w.vehicle_col     = 16'(vc);
    w.vehicle_row     = 16'(vr);
    w.vehicle_heading = 12'(hdg);
    return w;
  endfunction

  function automatic cone_word_t read_word(int row, int col);
    cone_word_t w;
    w           = '0;
    w.operation = OP_READ;
    w.query_row = 9'(row);
    w.query_col = 9'(col);
    return w;
  endfunction

  // Cone within about spread pixels of a map position (row counted downward)
  function automatic cone_word_t aimed_add(int ctr_row, int ctr_col, int spread,
                                          logic [7:0] cls);
    int lim;
    int cx;
    int cy;
    lim = (scale_ppm == 0) ? 32767 : spread * 65536 / int'(scale_ppm);
    if (lim > 32767) lim = 32767;
    if (lim < 1) lim = 1;
    cx = $urandom_range(1, lim);
    if ($urandom_range(0, 1) == 1) cx = -cx;
    cy = $urandom_range(1, lim);
    if ($urandom_range(0, 1) == 1) cy = -cy;
    return add_word(cx, cy, cls, ctr_col * 16 + int'($urandom_range(0, 15)),
                    (MAP_ROWS - ctr_row) * 16 + int'($urandom_range(0, 15)),
                    $urandom_range(0, 4095));
  endfunction

  // Send one cone word and queue its expected result
  task automatic send_word(input cone_word_t w);
    int           gap;
    result_word_t want;
    spot_t        sp;
    gap = steady_flow ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      cone_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cone_ch.valid <= 1'b1;
    cone_ch.data  <= w;
    do @(posedge clk); while (!cone_ch.ready);
    want = predict_evidence(w);
    evidence_due.push_back(want);
    if (w.operation == OP_READ) begin
      n_reads++;
      if ({want.channel_zero, want.channel_one, want.channel_two} != '0) n_lit_reads++;
      if (want.channel_zero == EVID_CAP || want.channel_one == EVID_CAP ||
          want.channel_two == EVID_CAP) n_capped++;
    end else begin
      n_adds++;
    end
    if (want.placed) begin
      n_placed++;
      sp.row = want.pixel_row[8:0];
      sp.col = want.pixel_col[8:0];
      spots.push_back(sp);
      if (spots.size() > SPOT_DEPTH) spots.delete(0);
    end
  endtask

  task automatic wait_results_drained();
    cone_ch.valid <= 1'b0;
    while (evidence_due.size() != 0) @(posedge clk);
  endtask

  // APB access: setup cycle then access cycle
  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == PPM_ADDR) scale_ppm = data[15:0];
  endtask

  task automatic apb_read(input logic [CFG_ADDR_W-1:0] addr, output logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    data = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_scale_readback();
    logic [31:0] rd;
    apb_read(PPM_ADDR, rd);
    if (rd[15:0] !== scale_ppm) begin
      $display("%0t: pixels_per_metre read expected 0x%h got 0x%h", $time, scale_ppm,
               rd[15:0]);
      fault_count++;
    end
  endtask

  // Change the scale once the map is quiet; upper data bits are don't-care
  task automatic program_scale(input logic [15:0] scale);
    wait_results_drained();
    apb_write(PPM_ADDR, {16'($urandom), scale});
    n_scales++;
    check_scale_readback();
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%h got 0x%h", $time, name, want, got);
      fault_count++;
    end
  endtask

  // Result sink: random stall per word, compare against oldest expectation
  always @(posedge clk) begin : result_sink
    result_word_t want;
    result_word_t got;
    int           pause;
    if (rst) begin
      res_ch.ready <= 1'b0;
      sink_hold    <= 0;
    end else if (res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (evidence_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none got %p", $time, got);
        fault_count++;
      end else begin
        want = evidence_due.pop_front();
        compare_field("placed", 16'(want.placed), 16'(got.placed));
        compare_field("pixel_col", want.pixel_col, got.pixel_col);
        compare_field("pixel_row", want.pixel_row, got.pixel_row);
        compare_field("channel_zero", 16'(want.channel_zero), 16'(got.channel_zero));
        compare_field("channel_one", 16'(want.channel_one), 16'(got.channel_one));
        compare_field("channel_two", 16'(want.channel_two), 16'(got.channel_two));
      end
      pause = steady_flow ? 0 : $urandom_range(0, 10);
      res_ch.ready <= (pause == 0);
      sink_hold    <= pause;
    end else if (sink_hold > 1) begin
      sink_hold <= sink_hold - 1;
    end else begin
      sink_hold    <= 0;
      res_ch.ready <= 1'b1;
    end
  end

  // Watchdog: cycles with no word moving on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cone_ch.valid && cone_ch.ready) || (res_ch.valid && res_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no word moved for %0d cycles", $time, quiet);
    $display("Regression FAIL");
    $finish;
  end

  // Reset value, then write and read back both extremes and a mixed pattern
  task automatic test_scale_register();
    check_scale_readback();
    program_scale(16'hFFFF);
    program_scale(16'h0000);
    program_scale(16'h5AA5);
    program_scale(PPM_RESET);
  endtask

  // Map border, truncation toward zero and zero coordinates at the reset scale
  task automatic test_map_border();
    send_word(add_word(1, 1, CLASS_ZERO, 0, 256 * 16, 0));
    send_word(add_word(1, 1, CLASS_ZERO, 16, 256 * 16, 0));
    send_word(add_word(1, 1, CLASS_ZERO, 510 * 16, 256 * 16, 0));
    send_word(add_word(1, 1, CLASS_ZERO, 511 * 16, 256 * 16, 0));
    send_word(add_word(1, 1, CLASS_ZERO, -16, 256 * 16, 0));
    send_word(add_word(1, 1, CLASS_TWO, 256 * 16, 512 * 16, 0));
    send_word(add_word(1, 1, CLASS_TWO, 256 * 16, 511 * 16, 0));
    send_word(add_word(1, 1, CLASS_TWO, 256 * 16, 2 * 16, 0));
    send_word(add_word(1, 1, CLASS_TWO, 256 * 16, 16, 0));
    send_word(add_word(0, 300, CLASS_ZERO, 256 * 16, 256 * 16, 100));
    send_word(add_word(-300, 0, CLASS_ZERO, 256 * 16, 256 * 16, 100));
    send_word(read_word(0, 0));
    send_word(read_word(MAP_ROWS - 1, MAP_COLS - 1));
    send_word(read_word(256, 1));
  endtask

  // Each mapped class and two unknown class codes across the heading quadrants at one spot
  task automatic test_class_lanes();
    send_word(add_word(1, 1, CLASS_ZERO, 256 * 16, 256 * 16, 0));
    send_word(add_word(1, 1, CLASS_ONE, 256 * 16, 256 * 16, 1024));
    send_word(add_word(1, 1, CLASS_TWO, 256 * 16, 256 * 16, 2048));
    send_word(add_word(1, 1, CLASS_UNKNOWN, 256 * 16, 256 * 16, 3072));
    send_word(add_word(-1, -1, CLASS_TOP, 256 * 16, 256 * 16, 4095));
    send_word(add_word(-1, 1, CLASS_ZERO, 256 * 16, 256 * 16, 512));
    send_word(read_word(256, 256));
    send_word(read_word(255, 257));
  endtask

  // Field extremes at full scale (saturated outputs) and a zero scale
  task automatic test_field_extremes();
    program_scale(16'hFFFF);
    send_word(add_word(32767, 32767, CLASS_ZERO, 32767, 32767, 0));
    send_word(add_word(-32768, -32768, CLASS_TWO, -32768, -32768, 2048));
    program_scale(16'h0000);
    send_word(add_word(-1, -1, CLASS_ONE, 100 * 16, 400 * 16, 3000));
    send_word(read_word(112, 100));
  endtask

  // Random phase: placements around busy spots, read-backs and noise
  task automatic test_random_mapping(input logic [15:0] scale, input int count);
    int           hot_row [3];
    int           hot_col [3];
    int           roll;
    int           pick;
    int           qr;
    int           qc;
    logic [7:0]   cls;
    logic [127:0] raw;
    spot_t        sp;
    cone_word_t   w;
    program_scale(scale);
    for (int k = 0; k < 3; k++) begin
      hot_row[k] = $urandom_range(10, MAP_ROWS - 12);
      hot_col[k] = $urandom_range(10, MAP_COLS - 12);
    end
    for (int n = 0; n < count; n++) begin
      // a stretch without stalls every 60 words
      steady_flow = (n % 60) >= 45;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        cls = ($urandom_range(0, 9) == 0) ? 8'($urandom) : MAPPED_CLASSES[$urandom_range(0, 2)];
        if ($urandom_range(0, 1) == 1) begin
          pick = $urandom_range(0, 2);
          w = aimed_add(hot_row[pick], hot_col[pick], 2, cls);
        end else begin
          w = aimed_add($urandom_range(30, MAP_ROWS - 32), $urandom_range(30, MAP_COLS - 32),
                        25, cls);
        end
      end else if (roll < 85) begin
        if (spots.size() != 0 && $urandom_range(0, 9) < 7) begin
          sp = spots[$urandom_range(0, spots.size() - 1)];
          qr = int'(sp.row) + int'($urandom_range(0, 4)) - 2;
          qc = int'(sp.col) + int'($urandom_range(0, 4)) - 2;
          qr = (qr < 0) ? 0 : (qr > MAP_ROWS - 1) ? MAP_ROWS - 1 : qr;
          qc = (qc < 0) ? 0 : (qc > MAP_COLS - 1) ? MAP_COLS - 1 : qc;
          w = read_word(qr, qc);
        end else begin
          w = read_word($urandom_range(0, 511), $urandom_range(0, 511));
        end
      end else begin
        raw = {$urandom, $urandom, $urandom, $urandom};
        w   = raw[$bits(cone_word_t)-1:0];
      end
      send_word(w);
    end
    steady_flow = 1'b0;
  endtask

  // Main sequence
  initial begin : main_seq
    int quad;
    int rem;
    int mag;
    for (int h = 0; h < 4096; h++) begin
      quad       = h / 1024;
      rem        = h % 1024;
      mag        = ((quad % 2) == 1) ? taylor_sin_q14(1024 - rem) : taylor_sin_q14(rem);
      sin_lut[h] = (quad >= 2) ? -mag : mag;
    end

    rst           = 1'b1;
    cone_ch.valid = 1'b0;
    cone_ch.data  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_scale_register();
    test_map_border();
    test_class_lanes();
    test_field_extremes();
    test_random_mapping(PPM_RESET, 140);
    test_random_mapping(16'hFFFF, 60);
    test_random_mapping(16'h0000, 30);
    test_random_mapping(16'h0001, 30);
    test_random_mapping(16'($urandom_range(1000, 40000)), 140);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d adds (%0d placed) and %0d cell reads over %0d scale settings",
             n_adds, n_placed, n_reads, n_scales);
    $display("Reads returned evidence in %0d cells, %0d of them at the cap",
             n_lit_reads, n_capped);
    if (fault_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
